@@ rtl/iss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iss_pkg
// Shared sizes, codes and types of the indexed sequence store.
// ----------------------------------------------------------------------------
package iss_pkg;

   localparam int CAPACITY      = 64;
   localparam int ADDR_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int DATA_W        = 32;
   localparam int POS_W         = 16;
   localparam int ACTION_W      = 3;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND   = 3'd0,
      ACT_PREPEND  = 3'd1,
      ACT_INSERT   = 3'd2,
      ACT_REMOVE   = 3'd3,
      ACT_GET      = 3'd4,
      ACT_CONTAINS = 3'd5,
      ACT_CLEAR    = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      action_type               action;
      logic [POS_W-1:0]         position;
      logic [DATA_W-1:0]        item_value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]        read_value;
      logic                     found;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      status_type               status;
   } result_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // Clamp a signed position into 0..upper.
   function automatic logic [CNT_W-1:0] clamp_index(input logic [POS_W-1:0] pos,
                                                   input logic [CNT_W-1:0] upper);
      logic [CNT_W-1:0] res;
      if (pos[POS_W-1]) begin
         res = '0;
      end else if (pos > POS_W'(upper)) begin
         res = upper;
      end else begin
         res = CNT_W'(pos);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

@@ rtl/iss_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iss_req_if
// Request channel: valid/ready handshake with action, position and value.
// ----------------------------------------------------------------------------
interface iss_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [15:0] position;
   logic [31:0] item_value;

   modport source (output valid, output action, output position, output item_value,
                   input ready);
   modport sink   (input valid, input action, input position, input item_value,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/iss_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iss_rsp_if
// Response channel: valid/ready handshake with value, flag, count, status.
// ----------------------------------------------------------------------------
interface iss_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_value;
   logic        found;
   logic [6:0]  entry_count;
   logic [1:0]  status;

   modport source (output valid, output read_value, output found, output entry_count,
                   output status, input ready);
   modport sink   (input valid, input read_value, input found, input entry_count,
                   input status, output ready);
endinterface
`default_nettype wire

@@ rtl/iss_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iss_ram
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iss_ram
   import iss_pkg::*;
(
   input  wire logic              clock,
   input  wire mem_req_type       mem_req,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/iss_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iss_ctrl
// Request sequencer: clamps indices, walks the entry memory one entry per
// cycle to shift, read or search, and keeps the entry count.
// ----------------------------------------------------------------------------
module iss_ctrl
   import iss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire req_type           req,
   output      mem_req_type       mem_req,
   input  wire logic [DATA_W-1:0] mem_rdata,
   output      logic              done,
   input  wire logic              slot_free,
   output      result_type        result
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_SHIFT_UP = 5'b00010,
      S_PUT      = 5'b00100,
      S_WALK     = 5'b01000,
      S_FINISH   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  at_ff, at_in;
   logic [CNT_W-1:0]  end_ff, end_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  pidx_ff, pidx_in;
   logic              issue_ff, issue_in;
   logic              pend_ff, pend_in;
   action_type        op_ff, op_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] rd_value_ff, rd_value_in;
   logic              found_ff, found_in;
   status_type        status_ff, status_in;

   logic [CNT_W-1:0]  ins_at;
   logic [CNT_W-1:0]  rem_at;
   logic [CNT_W-1:0]  last_idx;
   logic [CNT_W-1:0]  up_idx;
   logic [CNT_W-1:0]  down_idx;
   logic              is_full;
   logic              is_empty;

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign last_idx = count_ff - CNT_W'(1);
   assign up_idx   = pidx_ff + CNT_W'(1);
   assign down_idx = pidx_ff - CNT_W'(1);
   assign rem_at   = clamp_index(req.position, last_idx);

   always_comb begin
      case (req.action)
         ACT_APPEND:  ins_at = count_ff;
         ACT_PREPEND: ins_at = '0;
         default:     ins_at = clamp_index(req.position, count_ff);
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      at_in       = at_ff;
      end_in      = end_ff;
      rd_idx_in   = rd_idx_ff;
      issue_in    = issue_ff;
      op_in       = op_ff;
      val_in      = val_ff;
      rd_value_in = rd_value_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      mem_req     = '0;
      done        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req.action;
               val_in      = req.item_value;
               rd_value_in = '0;
               found_in    = 1'b0;
               status_in   = ST_OK;
               state_in    = S_FINISH;
               case (req.action)
                  ACT_APPEND, ACT_PREPEND, ACT_INSERT: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else if (ins_at == count_ff) begin
                        // tail insert: no shift needed
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = count_ff[ADDR_W-1:0];
                        mem_req.wr_data = req.item_value;
                        count_in        = count_ff + CNT_W'(1);
                     end else begin
                        at_in     = ins_at;
                        rd_idx_in = last_idx;
                        issue_in  = 1'b1;
                        state_in  = S_SHIFT_UP;
                     end
                  end
                  ACT_REMOVE, ACT_GET: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        at_in     = rem_at;
                        rd_idx_in = rem_at;
                        end_in    = (req.action == ACT_REMOVE) ? last_idx : rem_at;
                        issue_in  = 1'b1;
                        state_in  = S_WALK;
                     end
                  end
                  ACT_CONTAINS: begin
                     if (!is_empty) begin
                        rd_idx_in = '0;
                        end_in    = last_idx;
                        issue_in  = 1'b1;
                        state_in  = S_WALK;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SHIFT_UP: begin
            // read from the tail down to the insert point, write one slot higher
            if (issue_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_idx_ff[ADDR_W-1:0];
               if (rd_idx_ff == at_ff) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff - CNT_W'(1);
               end
            end
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = up_idx[ADDR_W-1:0];
               mem_req.wr_data = mem_rdata;
               if (pidx_ff == at_ff) begin
                  state_in = S_PUT;
               end
            end
         end

         S_PUT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = at_ff[ADDR_W-1:0];
            mem_req.wr_data = val_ff;
            count_in        = count_ff + CNT_W'(1);
            state_in        = S_FINISH;
         end

         S_WALK: begin
            if (issue_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_idx_ff[ADDR_W-1:0];
               if (rd_idx_ff == end_ff) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
               end
            end
            if (pend_ff) begin
               case (op_ff)
                  ACT_REMOVE: begin
                     // capture the removed entry, pull the rest down one slot
                     if (pidx_ff == at_ff) begin
                        rd_value_in = mem_rdata;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = down_idx[ADDR_W-1:0];
                        mem_req.wr_data = mem_rdata;
                     end
                  end
                  ACT_GET: begin
                     rd_value_in = mem_rdata;
                  end
                  ACT_CONTAINS: begin
                     if (mem_rdata == val_ff) begin
                        found_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (pidx_ff == end_ff) begin
                  if (op_ff == ACT_REMOVE) begin
                     count_in = last_idx;
                  end
                  state_in = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            done = 1'b1;
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      pend_in = mem_req.rd_en;
      pidx_in = rd_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         issue_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      at_ff       <= at_in;
      end_ff      <= end_in;
      rd_idx_ff   <= rd_idx_in;
      pidx_ff     <= pidx_in;
      op_ff       <= op_in;
      val_ff      <= val_in;
      rd_value_ff <= rd_value_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign result.read_value  = rd_value_ff;
   assign result.found       = found_ff;
   assign result.entry_count = ENTRY_COUNT_W'(count_ff);
   assign result.status      = status_ff;

endmodule
`default_nettype wire

@@ rtl/indexed_sequence_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Bounded ordered list of signed 32-bit values with insert/remove by index.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request per handshake: action (append, prepend,
//   insert, remove, get, contains, clear), a signed position and a value.
//   rsp_ch returns exactly one response per request, in order: read value,
//   found flag, entry count after the request and a status code.
//   One request is in work at a time; req_ch.ready is high while idle, and
//   a new request can be taken the cycle after the response register loads.
//   Tail append, clear, refused and empty requests need no memory walk; an
//   insert at index k first shifts the entries from the tail down to k,
//   a remove at k walks from k to the tail, a get reads entry k and a
//   contains walks every entry. The walks are bounded by the entry
//   memory's single read port, which walks one entry per cycle.
//   Reset (synchronous) empties the list and drops any pending response;
//   the memory itself is not cleared.
//   A stalled response waits in the output register; the next request is
//   accepted meanwhile and its result holds inside until the register frees.
// ----------------------------------------------------------------------------
module indexed_sequence_store
   import iss_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   iss_req_if.sink    req_ch,
   iss_rsp_if.source  rsp_ch
);

   req_type           req;
   mem_req_type       mem_req;
   logic [DATA_W-1:0] mem_rdata;
   logic              done;
   logic              slot_free;
   result_type        result;
   result_type        out_ff;
   logic              out_valid_ff, out_valid_in;

   assign req.action     = action_type'(req_ch.action);
   assign req.position   = req_ch.position;
   assign req.item_value = req_ch.item_value;

   iss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req       (req),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .done      (done),
      .slot_free (slot_free),
      .result    (result)
   );

   iss_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rdata)
   );

   assign slot_free = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (done && slot_free) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done && slot_free) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.read_value  = out_ff.read_value;
   assign rsp_ch.found       = out_ff.found;
   assign rsp_ch.entry_count = out_ff.entry_count;
   assign rsp_ch.status      = out_ff.status;

   // one request at a time: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while another is in work");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_FULL) |->
         rsp_ch.entry_count == ENTRY_COUNT_W'(CAPACITY))
      else $error("full status with a count below capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_EMPTY) |->
         (rsp_ch.entry_count == '0 && rsp_ch.read_value == '0))
      else $error("empty status with entries or a read value");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.found) |-> rsp_ch.status == ST_OK)
      else $error("found flag with an error status");

endmodule
`default_nettype wire
